FILE: rtl/core/esd_pkg.sv
package esd_pkg;

   // parse state of the front end
   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_OCT   = 2'd2,
      MODE_HEX   = 2'd3
   } parse_mode_type;

   // back end: first or second byte of a queued entry
   typedef enum logic {
      BACK_FIRST  = 1'b0,
      BACK_SECOND = 1'b1
   } back_state_type;

   // one or two decoded bytes caused by one request
   typedef struct packed {
      logic       two;
      logic [7:0] second;
      logic [7:0] first;
   } job_type;

   // back end status seen by the top level
   typedef struct packed {
      logic on_second;
      logic pop;
   } back_status_type;

   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_ZERO      = 8'h30;
   localparam logic [7:0] CHR_SEVEN     = 8'h37;
   localparam logic [7:0] CHR_NINE      = 8'h39;
   localparam logic [7:0] CHR_LOW_A     = 8'h61;
   localparam logic [7:0] CHR_LOW_B     = 8'h62;
   localparam logic [7:0] CHR_LOW_E     = 8'h65;
   localparam logic [7:0] CHR_LOW_F     = 8'h66;
   localparam logic [7:0] CHR_LOW_N     = 8'h6E;
   localparam logic [7:0] CHR_LOW_R     = 8'h72;
   localparam logic [7:0] CHR_LOW_T     = 8'h74;
   localparam logic [7:0] CHR_LOW_V     = 8'h76;
   localparam logic [7:0] CHR_LOW_X     = 8'h78;
   localparam logic [7:0] CHR_UP_A      = 8'h41;
   localparam logic [7:0] CHR_UP_F      = 8'h46;

   localparam logic [7:0] CTL_BEL = 8'h07;
   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_ESC = 8'h1B;
   localparam logic [7:0] CTL_FF  = 8'h0C;
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_CR  = 8'h0D;
   localparam logic [7:0] CTL_HT  = 8'h09;
   localparam logic [7:0] CTL_VT  = 8'h0B;

   localparam logic [1:0] OCT_LAST_COUNT = 2'd2;
   localparam logic [1:0] HEX_LAST_COUNT = 2'd1;

endpackage

FILE: rtl/core/esd_front.sv
module esd_front
   import esd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wen,
   input  logic       csr_wdata,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_string,
   output logic       push,
   output job_type    job
);

   logic           enabled_ff;
   parse_mode_type mode_ff, mode_in;
   logic [1:0]     count_ff, count_in;
   logic [7:0]     value_ff, value_in;

   logic           digit_ok;
   logic           number_done;
   logic [7:0]     acc;
   logic           hex_ok;
   logic [3:0]     hex_val;
   logic           is_bs;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         mode_ff    <= MODE_PLAIN;
         count_ff   <= 2'd0;
         value_ff   <= 8'd0;
      end else begin
         if (csr_wen) begin
            enabled_ff <= csr_wdata;
         end
         mode_ff  <= mode_in;
         count_ff <= count_in;
         value_ff <= value_in;
      end
   end

   // digit decode for octal and hex numbers
   always_comb begin
      is_bs   = (in_byte == CHR_BACKSLASH);
      hex_ok  = 1'b0;
      hex_val = 4'd0;
      if (in_byte >= CHR_ZERO && in_byte <= CHR_NINE) begin
         hex_ok  = 1'b1;
         hex_val = 4'(in_byte - CHR_ZERO);
      end else if (in_byte >= CHR_LOW_A && in_byte <= CHR_LOW_F) begin
         hex_ok  = 1'b1;
         hex_val = 4'(in_byte - CHR_LOW_A + 8'd10);
      end else if (in_byte >= CHR_UP_A && in_byte <= CHR_UP_F) begin
         hex_ok  = 1'b1;
         hex_val = 4'(in_byte - CHR_UP_A + 8'd10);
      end
      if (mode_ff == MODE_OCT) begin
         digit_ok    = (in_byte >= CHR_ZERO) && (in_byte <= CHR_SEVEN);
         acc         = {value_ff[4:0], in_byte[2:0]};
         number_done = (count_ff == OCT_LAST_COUNT);
      end else begin
         digit_ok    = hex_ok;
         acc         = {value_ff[3:0], hex_val};
         number_done = (count_ff == HEX_LAST_COUNT);
      end
   end

   // next parse state
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      value_in = value_ff;
      if (accept) begin
         if (!enabled_ff) begin
            mode_in  = MODE_PLAIN;
            count_in = 2'd0;
            value_in = 8'd0;
         end else begin
            case (mode_ff)
               MODE_PLAIN: begin
                  mode_in = (is_bs && !end_of_string) ? MODE_ESC : MODE_PLAIN;
               end
               MODE_ESC: begin
                  mode_in = MODE_PLAIN;
                  if (in_byte == CHR_ZERO) begin
                     count_in = 2'd0;
                     value_in = 8'd0;
                     if (!end_of_string) mode_in = MODE_OCT;
                  end else if (in_byte == CHR_LOW_X) begin
                     count_in = 2'd0;
                     value_in = 8'd0;
                     if (!end_of_string) mode_in = MODE_HEX;
                  end
               end
               default: begin
                  if (!digit_ok) begin
                     mode_in  = (is_bs && !end_of_string) ? MODE_ESC : MODE_PLAIN;
                     count_in = 2'd0;
                     value_in = 8'd0;
                  end else if (number_done || end_of_string) begin
                     mode_in  = MODE_PLAIN;
                     count_in = 2'd0;
                     value_in = 8'd0;
                  end else begin
                     count_in = count_ff + 2'd1;
                     value_in = acc;
                  end
               end
            endcase
         end
         if (end_of_string) begin
            mode_in  = MODE_PLAIN;
            count_in = 2'd0;
            value_in = 8'd0;
         end
      end
   end

   // decoded bytes for this request
   always_comb begin
      push       = 1'b0;
      job.two    = 1'b0;
      job.first  = in_byte;
      job.second = in_byte;
      if (!enabled_ff) begin
         push = 1'b1;
      end else begin
         case (mode_ff)
            MODE_PLAIN: begin
               push = !is_bs || end_of_string;
            end
            MODE_ESC: begin
               push = 1'b1;
               case (in_byte)
                  CHR_BACKSLASH: job.first = CHR_BACKSLASH;
                  CHR_LOW_A:     job.first = CTL_BEL;
                  CHR_LOW_B:     job.first = CTL_BS;
                  CHR_LOW_E:     job.first = CTL_ESC;
                  CHR_LOW_F:     job.first = CTL_FF;
                  CHR_LOW_N:     job.first = CTL_LF;
                  CHR_LOW_R:     job.first = CTL_CR;
                  CHR_LOW_T:     job.first = CTL_HT;
                  CHR_LOW_V:     job.first = CTL_VT;
                  CHR_ZERO: begin
                     push      = end_of_string;
                     job.first = 8'd0;
                  end
                  CHR_LOW_X: begin
                     push      = end_of_string;
                     job.two   = 1'b1;
                     job.first = CHR_BACKSLASH;
                  end
                  default: begin
                     job.two   = 1'b1;
                     job.first = CHR_BACKSLASH;
                  end
               endcase
            end
            default: begin
               if (!digit_ok) begin
                  // number ended early, then the byte is plain text unless it is a backslash that opens a new escape
                  push      = 1'b1;
                  job.first = value_ff;
                  job.two   = !is_bs || end_of_string;
               end else begin
                  push      = number_done || end_of_string;
                  job.first = acc;
               end
            end
         endcase
      end
      push = push && accept;
   end

endmodule

FILE: rtl/core/esd_queue.sv
module esd_queue
   import esd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type           mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = mem[rd_ptr_ff];
   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);

endmodule

FILE: rtl/core/esd_back.sv
module esd_back
   import esd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  job_type         head_job,
   input  logic            rsp_tready,
   output logic            rsp_tvalid,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tlast,
   output back_status_type status
);

   back_state_type state_ff, state_in;
   logic           handshake;

   assign handshake = head_valid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_FIRST;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_FIRST: begin
            if (handshake && head_job.two) state_in = BACK_SECOND;
         end
         BACK_SECOND: begin
            if (handshake) state_in = BACK_FIRST;
         end
         default: state_in = BACK_FIRST;
      endcase
   end

   // outputs
   always_comb begin
      rsp_tvalid       = head_valid;
      status.on_second = (state_ff == BACK_SECOND);
      case (state_ff)
         BACK_FIRST: begin
            rsp_tdata = head_job.first;
            rsp_tlast = !head_job.two;
         end
         BACK_SECOND: begin
            rsp_tdata = head_job.second;
            rsp_tlast = 1'b1;
         end
         default: begin
            rsp_tdata = head_job.first;
            rsp_tlast = 1'b1;
         end
      endcase
      status.pop = handshake && rsp_tlast;
   end

endmodule

FILE: rtl/core/escape_sequence_decoder_top.sv
// channel  | direction | tdata / tuser / tlast
// req      | in        | tdata[7:0] in_byte, tlast end_of_string
// rsp      | out       | tdata[7:0] out_byte, tlast last_of_run
// csr      | in        | csr_wdata escapes_enabled, written when csr_wen is high
//
// one request is taken every cycle while the decode queue has room
// a request that decodes to two bytes holds the result side until both bytes are taken
// requests that decode to nothing (backslash, escape prefix, digits) put no entry in the queue
// reset is synchronous and active high: escapes off, plain-text mode, queue empty
// the front parser and the result side stall independently through the queue
module escape_sequence_decoder_top
   import esd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wen,
   input  logic       csr_wdata,    // escapes_enabled
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,    // end_of_string
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tlast     // last_of_run
);

   logic            req_accept;
   logic            push;
   job_type         push_job;
   job_type         head_job;
   logic            q_full;
   logic            q_empty;
   back_status_type back_status;

   // front end takes a request whenever the queue has a free slot
   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   // parser: escape state and the escapes_enabled register
   esd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .accept        (req_accept),
      .in_byte       (req_tdata),
      .end_of_string (req_tlast),
      .push          (push),
      .job           (push_job)
   );

   // decoded entries waiting for the result side
   esd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (back_status.pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // result side: one or two bytes per entry
   esd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head_job   (head_job),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .status     (back_status)
   );

   // queue can never look full and empty at once
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue full and empty together");

   // second byte of an entry is only pending while the entry is present
   a_second_has_entry: assert property (@(posedge clock) disable iff (reset)
      back_status.on_second |-> rsp_tvalid)
      else $error("second byte pending with empty queue");

   // a non-final byte of a request is always followed by the rest of that request
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && back_status.on_second))
      else $error("run cut short");

   // a full queue never takes another entry
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("push into full queue");

endmodule
